### hw/rtl/tdczs_pkg.sv
// Package of shared types and constants for the TDC zero-suppressing packer.
package tdczs_pkg;

  // Read passes carried by one transaction; each pass has a lane of its own.
  localparam int LANES       = 2;
  // Passes that are looked at, in order; hits on lanes beyond this are ignored.
  localparam int READ_PASSES = 2;

  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 8;
  localparam int IDENT_W = 8;
  localparam int CAP_W   = 13;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = CAP_W;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULE_IDENT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_CAPACITY = 2'd1;
  localparam logic [IDENT_W-1:0]     IDENT_RESET         = 8'd0;
  localparam logic [CAP_W-1:0]       CAP_RESET           = 13'd129;

  // Word formats.
  localparam logic [15:0]       HIT_MASK  = 16'hffff;
  localparam logic [7:0]        HDR_MARK  = 8'hfe;
  localparam logic [SLOT_W-1:0] COUNT_MAX = 8'hff;

  // Result queue.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [SLOT_W-1:0] slot;
    logic              err;
    logic              done;
  } result_t;

  // Configuration registers as seen by the packing logic.
  typedef struct packed {
    logic [IDENT_W-1:0] module_ident;
    logic [CAP_W-1:0]   buffer_capacity;
  } cfg_t;

  // Results produced by one accepted transaction, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### hw/rtl/tdc_zero_suppress_packer.sv
// Top level of the TDC zero-suppressing event packer.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  reading_first, reading_second, final_channel
//   output   out        out_valid/out_stall  packed_word, buffer_slot, overflow_error,
//                                            event_done
//   config   in         cfg_write            cfg_index, cfg_data
//
// One input transaction is taken per cycle while in_stall is low; its results enter the
// result queue at the same edge and leave it one per cycle while out_stall is low.
// A hit on the last channel yields two results, so the output side sets the rate
// then: the four-entry queue stalls input while fewer than two entries are free.
// Reset (synchronous) empties the queue, clears the event state and restores the
// registers to module id 0 and capacity 129.
module tdc_zero_suppress_packer #(
  parameter int READ_PASSES = tdczs_pkg::READ_PASSES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tdczs_pkg::WORD_W-1:0]      reading_first,
  input  logic [tdczs_pkg::WORD_W-1:0]      reading_second,
  input  logic                              final_channel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tdczs_pkg::WORD_W-1:0]      packed_word,
  output logic [tdczs_pkg::SLOT_W-1:0]      buffer_slot,
  output logic                              overflow_error,
  output logic                              event_done,
  input  logic                              cfg_write,
  input  logic [tdczs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tdczs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tdczs_pkg::cfg_t    cfg;
  tdczs_pkg::push_t   push;
  tdczs_pkg::result_t head;
  logic               accept;
  logic               full;
  logic [tdczs_pkg::LANES-1:0][tdczs_pkg::WORD_W-1:0] readings;
  logic [tdczs_pkg::LANES-1:0]                        lane_hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.module_ident    <= tdczs_pkg::IDENT_RESET;
      cfg.buffer_capacity <= tdczs_pkg::CAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tdczs_pkg::REG_MODULE_IDENT:    cfg.module_ident    <= cfg_data[tdczs_pkg::IDENT_W-1:0];
        tdczs_pkg::REG_BUFFER_CAPACITY: cfg.buffer_capacity <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  assign readings[0] = reading_first;
  assign readings[1] = reading_second;

  // One hit detector per read pass.
  for (genvar i = 0; i < tdczs_pkg::LANES; i++) begin : g_lane
    tdczs_lane u_lane (
      .reading (readings[i]),
      .hit     (lane_hit[i])
    );
  end

  tdczs_merge #(
    .READ_PASSES (READ_PASSES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .readings      (readings),
    .lane_hit      (lane_hit),
    .final_channel (final_channel),
    .cfg           (cfg),
    .push          (push)
  );

  tdczs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign packed_word    = head.word;
  assign buffer_slot    = head.slot;
  assign overflow_error = head.err;
  assign event_done     = head.done;

endmodule

### hw/rtl/tdczs_lane.sv
// Hit detection for one read pass of a channel.
module tdczs_lane (
  input  logic [tdczs_pkg::WORD_W-1:0] reading,
  output logic                         hit
);

  // A reading is a hit when any of its low 16 bits is set.
  assign hit = (reading[15:0] & tdczs_pkg::HIT_MASK) != 16'd0;

endmodule

### hw/rtl/tdczs_merge.sv
// Merging stage: selects the first hit lane, keeps the event state and forms results.
module tdczs_merge #(
  parameter int READ_PASSES = tdczs_pkg::READ_PASSES
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        accept,
  input  logic [tdczs_pkg::LANES-1:0][tdczs_pkg::WORD_W-1:0] readings,
  input  logic [tdczs_pkg::LANES-1:0]                 lane_hit,
  input  logic                                        final_channel,
  input  tdczs_pkg::cfg_t                             cfg,
  output tdczs_pkg::push_t                            push
);

  logic [tdczs_pkg::SLOT_W-1:0] hit_count, hit_count_next;
  logic                         event_dropped, event_dropped_next;

  logic                         hit;
  logic [tdczs_pkg::WORD_W-1:0] word;
  logic [tdczs_pkg::SLOT_W:0]   slot_wide;
  logic                         overflow;
  logic [tdczs_pkg::SLOT_W-1:0] count_after;
  tdczs_pkg::result_t           data_res, hdr_res, err_res;

  // Priority select: the lowest enabled lane with a hit wins.
  always_comb begin
    hit  = 1'b0;
    word = '0;
    for (int i = tdczs_pkg::LANES - 1; i >= 0; i--) begin
      if (lane_hit[i] && (i < READ_PASSES)) begin
        hit  = 1'b1;
        word = readings[i];
      end
    end
  end

  // The next data slot must lie below the capacity and the counter must not be full.
  always_comb begin
    slot_wide = {1'b0, hit_count} + {{tdczs_pkg::SLOT_W{1'b0}}, 1'b1};
    overflow  = hit && ((hit_count == tdczs_pkg::COUNT_MAX) ||
                ({{(tdczs_pkg::CAP_W-tdczs_pkg::SLOT_W-1){1'b0}}, slot_wide} >=
                 cfg.buffer_capacity));
    count_after = hit ? slot_wide[tdczs_pkg::SLOT_W-1:0] : hit_count;
  end

  // Result words.
  always_comb begin
    data_res.word = word;
    data_res.slot = slot_wide[tdczs_pkg::SLOT_W-1:0];
    data_res.err  = 1'b0;
    data_res.done = 1'b0;

    hdr_res.word  = {tdczs_pkg::HDR_MARK, cfg.module_ident, 6'd0, 1'b1, 1'b0, count_after};
    hdr_res.slot  = '0;
    hdr_res.err   = 1'b0;
    hdr_res.done  = 1'b1;

    err_res.word  = '0;
    err_res.slot  = '0;
    err_res.err   = 1'b1;
    err_res.done  = 1'b1;
  end

  // Results and state update for the current transaction.
  always_comb begin
    push               = '0;
    push.first         = hdr_res;
    push.second        = hdr_res;
    hit_count_next     = hit_count;
    event_dropped_next = event_dropped;
    if (accept) begin
      if (event_dropped) begin
        // Rest of an abandoned event: nothing is emitted for it, its last channel included.
        if (final_channel) begin
          event_dropped_next = 1'b0;
          hit_count_next     = '0;
        end
      end else if (overflow) begin
        push.count         = 2'd1;
        push.first         = err_res;
        hit_count_next     = '0;
        event_dropped_next = !final_channel;
      end else begin
        if (hit) begin
          push.first = data_res;
          if (final_channel) begin
            push.count = 2'd2;
          end else begin
            push.count = 2'd1;
          end
        end else if (final_channel) begin
          push.count = 2'd1;
        end
        hit_count_next = final_channel ? '0 : count_after;
      end
    end
  end

  // Event state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count     <= '0;
      event_dropped <= 1'b0;
    end else begin
      hit_count     <= hit_count_next;
      event_dropped <= event_dropped_next;
    end
  end

endmodule

### hw/rtl/tdczs_queue.sv
// Result queue: takes up to two results a cycle and delivers one a cycle while out_stall is low.
module tdczs_queue (
  input  logic               clk,
  input  logic               rst,
  input  tdczs_pkg::push_t   push,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output tdczs_pkg::result_t head
);

  tdczs_pkg::result_t             entries [tdczs_pkg::QDEPTH];
  logic [tdczs_pkg::QPTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [tdczs_pkg::QPTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [tdczs_pkg::QCOUNT_W-1:0] count, count_next;
  logic                           pop;
  logic [tdczs_pkg::QPTR_W-1:0]   wr_ptr_plus;

  assign out_valid   = count != '0;
  assign pop         = out_valid && !out_stall;
  assign head        = entries[rd_ptr];
  assign wr_ptr_plus = wr_ptr + {{(tdczs_pkg::QPTR_W-1){1'b0}}, 1'b1};

  // Room for a full pair of results is needed before a transaction is taken.
  assign full = count > tdczs_pkg::QCOUNT_W'(tdczs_pkg::QDEPTH - 2);

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_next = wr_ptr + push.count[tdczs_pkg::QPTR_W-1:0];
    rd_ptr_next = rd_ptr + {{(tdczs_pkg::QPTR_W-1){1'b0}}, pop};
    count_next  = count + {{(tdczs_pkg::QCOUNT_W-2){1'b0}}, push.count}
                        - {{(tdczs_pkg::QCOUNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Result storage; the first result of a transaction goes in ahead of the second.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus] <= push.second;
    end
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the TDC zero-suppressing event packer.
`timescale 1ns / 1ps

module testbench;

  // Register index with no register behind it; writes to it must change nothing.
  localparam logic [tdczs_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd2;

  typedef enum int {FLOW, LIGHT, HEAVY, PERIODIC} stall_pattern_t;

  // One row of the directed table: either a register setting or one channel.
  typedef struct packed {
    logic                              reconfig;
    logic [tdczs_pkg::IDENT_W-1:0]     ident;
    logic [tdczs_pkg::CAP_W-1:0]       capacity;
    logic [tdczs_pkg::WORD_W-1:0]      word_a;
    logic [tdczs_pkg::WORD_W-1:0]      word_b;
    logic                              last;
    logic                              typed;
    logic [1:0]                        count;
    tdczs_pkg::result_t                res0;
    tdczs_pkg::result_t                res1;
  } channel_row_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [tdczs_pkg::WORD_W-1:0]      reading_first;
  logic [tdczs_pkg::WORD_W-1:0]      reading_second;
  logic                              final_channel;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [tdczs_pkg::WORD_W-1:0]      packed_word;
  logic [tdczs_pkg::SLOT_W-1:0]      buffer_slot;
  logic                              overflow_error;
  logic                              event_done;
  logic                              cfg_write;
  logic [tdczs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tdczs_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Expected results of the transaction on the input port, where typed in by hand.
  logic               row_typed;
  logic [1:0]         row_count;
  tdczs_pkg::result_t row_res0;
  tdczs_pkg::result_t row_res1;

  // Predicted block state and register copies.
  logic [tdczs_pkg::IDENT_W-1:0] cur_ident;
  logic [tdczs_pkg::CAP_W-1:0]   cur_capacity;
  logic [tdczs_pkg::SLOT_W-1:0]  tally;
  logic                          abandoned;

  tdczs_pkg::result_t pending_results[$];
  channel_row_t       directed_rows[$];
  int                 mismatch_count = 0;
  int                 burst_left = 0;
  bit                 gaps_on;

  stall_pattern_t stall_mode = FLOW;
  int             stall_left = 0;
  logic [7:0]     stall_tick = '0;

  tdc_zero_suppress_packer dut (.*);

  always #2 clk = ~clk;

  // The run is abandoned if it has not finished well within this time.
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic tdczs_pkg::result_t make_result(
      input logic [tdczs_pkg::WORD_W-1:0] word,
      input logic [tdczs_pkg::SLOT_W-1:0] slot,
      input logic err, input logic done);
    tdczs_pkg::result_t r;
    r.word = word;
    r.slot = slot;
    r.err  = err;
    r.done = done;
    return r;
  endfunction

  // A channel reading; a hit has a nonzero low half, otherwise the low half is clear.
  function automatic logic [tdczs_pkg::WORD_W-1:0] reading(input bit hit);
    logic [tdczs_pkg::WORD_W-1:0] w;
    w = $urandom;
    if (!hit) begin
      w[15:0] = 16'h0;
    end else if ($urandom_range(0, 7) == 0) begin
      w[15:0] = 16'h1 << $urandom_range(0, 15);
    end else if (w[15:0] == 16'h0) begin
      w[0] = 1'b1;
    end
    return w;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Packs one channel into the event and returns the results it causes, in order.
  task automatic pack_channel(input logic [tdczs_pkg::WORD_W-1:0] word_a,
                              input logic [tdczs_pkg::WORD_W-1:0] word_b,
                              input logic last, output int n,
                              output tdczs_pkg::result_t r0,
                              output tdczs_pkg::result_t r1);
    logic                         hit;
    logic [tdczs_pkg::WORD_W-1:0] word;
    logic [8:0]                   slot;
    tdczs_pkg::result_t           header;
    n = 0;
    r0 = '0;
    r1 = '0;
    hit = 1'b0;
    word = '0;
    // An abandoned event swallows everything up to its last channel.
    if (abandoned) begin
      if (last) begin
        abandoned = 1'b0;
        tally = '0;
      end
      return;
    end
    if (tdczs_pkg::READ_PASSES >= 1 && (word_a[15:0] & tdczs_pkg::HIT_MASK) != 16'h0) begin
      hit = 1'b1;
      word = word_a;
    end else if (tdczs_pkg::READ_PASSES >= 2 &&
                 (word_b[15:0] & tdczs_pkg::HIT_MASK) != 16'h0) begin
      hit = 1'b1;
      word = word_b;
    end
    if (hit) begin
      slot = {1'b0, tally} + 9'd1;
      // Full buffer or full counter: one error result and the event is dropped.
      if (tally == tdczs_pkg::COUNT_MAX || 32'(slot) >= 32'(cur_capacity)) begin
        r0 = make_result('0, '0, 1'b1, 1'b1);
        n = 1;
        tally = '0;
        abandoned = !last;
        return;
      end
      r0 = make_result(word, slot[7:0], 1'b0, 1'b0);
      n = 1;
      tally = slot[7:0];
    end
    // The header closes the event at slot 0.
    if (last) begin
      header = make_result({tdczs_pkg::HDR_MARK, cur_ident, 6'd0, 1'b1, 1'b0, tally}, '0,
                           1'b0, 1'b1);
      if (n == 0) r0 = header;
      else r1 = header;
      n++;
      tally = '0;
    end
  endtask

  // Prediction on accepted input transactions and checking of accepted results.
  always @(posedge clk) begin : scoreboard
    int                 n;
    tdczs_pkg::result_t p0;
    tdczs_pkg::result_t p1;
    tdczs_pkg::result_t got;
    tdczs_pkg::result_t want;
    if (rst) begin
      cur_ident = tdczs_pkg::IDENT_RESET;
      cur_capacity = tdczs_pkg::CAP_RESET;
      tally = '0;
      abandoned = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tdczs_pkg::REG_MODULE_IDENT: cur_ident = cfg_data[tdczs_pkg::IDENT_W-1:0];
          tdczs_pkg::REG_BUFFER_CAPACITY: cur_capacity = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pack_channel(reading_first, reading_second, final_channel, n, p0, p1);
        if (row_typed) begin
          n = int'(row_count);
          p0 = row_res0;
          p1 = row_res1;
        end
        if (n > 0) pending_results.push_back(p0);
        if (n > 1) pending_results.push_back(p1);
      end
      if (out_valid && !out_stall) begin
        got = make_result(packed_word, buffer_slot, overflow_error, event_done);
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result word %h slot %0d err %b done %b",
                                  got.word, got.slot, got.err, got.done));
        end else begin
          want = pending_results.pop_front();
          if (got.word !== want.word)
            note_mismatch($sformatf("packed_word %h, expected %h", got.word, want.word));
          if (got.slot !== want.slot)
            note_mismatch($sformatf("buffer_slot %0d, expected %0d", got.slot, want.slot));
          if (got.err !== want.err)
            note_mismatch($sformatf("overflow_error %b, expected %b", got.err, want.err));
          if (got.done !== want.done)
            note_mismatch($sformatf("event_done %b, expected %b", got.done, want.done));
        end
      end
    end
  end

  // The receiver changes its stall pattern at random intervals.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      FLOW:    out_stall <= 1'b0;
      LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
      HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_tick[2];
    endcase
  end

  task automatic write_register(input logic [tdczs_pkg::CFG_INDEX_W-1:0] index,
                                input logic [tdczs_pkg::CFG_DATA_W-1:0] data);
    cfg_index = index;
    cfg_data = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Registers change only once the block has delivered everything and gone quiet.
  task automatic set_config(input logic [tdczs_pkg::IDENT_W-1:0] ident,
                            input logic [tdczs_pkg::CAP_W-1:0] capacity);
    logic [tdczs_pkg::CFG_DATA_W-1:0] spare;
    spare = tdczs_pkg::CFG_DATA_W'($urandom);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_register(tdczs_pkg::REG_MODULE_IDENT,
                   {spare[tdczs_pkg::CFG_DATA_W-1:tdczs_pkg::IDENT_W], ident});
    write_register(tdczs_pkg::REG_BUFFER_CAPACITY, capacity);
  endtask

  // Offers one channel transaction, with bursts and gaps when gaps_on is set, and holds it until taken.
  task automatic send_channel(input logic [tdczs_pkg::WORD_W-1:0] word_a,
                              input logic [tdczs_pkg::WORD_W-1:0] word_b,
                              input logic last, input logic typed, input logic [1:0] count,
                              input tdczs_pkg::result_t r0, input tdczs_pkg::result_t r1);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    reading_first = word_a;
    reading_second = word_b;
    final_channel = last;
    row_typed = typed;
    row_count = count;
    row_res0 = r0;
    row_res1 = r1;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic add_row(input logic [tdczs_pkg::WORD_W-1:0] word_a,
                         input logic [tdczs_pkg::WORD_W-1:0] word_b,
                         input logic last, input logic typed, input logic [1:0] count,
                         input tdczs_pkg::result_t r0, input tdczs_pkg::result_t r1);
    channel_row_t row;
    row = '0;
    row.word_a = word_a;
    row.word_b = word_b;
    row.last = last;
    row.typed = typed;
    row.count = count;
    row.res0 = r0;
    row.res1 = r1;
    directed_rows.push_back(row);
  endtask

  task automatic add_setting(input logic [tdczs_pkg::IDENT_W-1:0] ident,
                             input logic [tdczs_pkg::CAP_W-1:0] capacity);
    channel_row_t row;
    row = '0;
    row.reconfig = 1'b1;
    row.ident = ident;
    row.capacity = capacity;
    directed_rows.push_back(row);
  endtask

  // Random events of random length; a few transactions are pure noise.
  task automatic run_events(input int budget);
    int                           sent;
    int                           len;
    int                           density;
    int                           kind;
    logic [tdczs_pkg::WORD_W-1:0] wa;
    logic [tdczs_pkg::WORD_W-1:0] wb;
    logic                         last;
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: density = 0;
        1: density = 30;
        2: density = 70;
        default: density = 100;
      endcase
      for (int c = 0; c < len; c++) begin
        last = (c == len - 1);
        kind = ($urandom_range(1, 100) <= density) ? $urandom_range(1, 3) : 0;
        case (kind)
          1: begin
            wa = reading(1'b1);
            wb = reading(1'($urandom_range(0, 1)));
          end
          2: begin
            wa = reading(1'b0);
            wb = reading(1'b1);
          end
          3: begin
            wa = reading(1'b1);
            wb = reading(1'b1);
          end
          default: begin
            wa = reading(1'b0);
            wb = reading(1'b0);
          end
        endcase
        if ($urandom_range(0, 19) == 0) begin
          wa = $urandom;
          wb = $urandom;
          last = 1'($urandom_range(0, 1));
        end
        send_channel(wa, wb, last, 1'b0, 2'd0, '0, '0);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    channel_row_t                  row;
    tdczs_pkg::result_t            none;
    tdczs_pkg::result_t            overflow;
    logic [tdczs_pkg::CAP_W-1:0]   capacity;
    logic [tdczs_pkg::IDENT_W-1:0] ident;
    none = '0;
    overflow = make_result('0, '0, 1'b1, 1'b1);
    rst = 1'b1;
    in_valid = 1'b0;
    reading_first = '0;
    reading_second = '0;
    final_channel = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_count = '0;
    row_res0 = '0;
    row_res1 = '0;

    // Directed table: reset registers first, then overflow, zero, unit and maximum capacity.
    add_row(32'h0, 32'h0, 1'b1, 1'b1, 2'd1, make_result(32'hfe000200, 8'd0, 1'b0, 1'b1), none);
    add_row(32'h1, 32'h0, 1'b0, 1'b1, 2'd1, make_result(32'h1, 8'd1, 1'b0, 1'b0), none);
    add_row(32'hffff0000, 32'hffffffff, 1'b0, 1'b1, 2'd1,
            make_result(32'hffffffff, 8'd2, 1'b0, 1'b0), none);
    add_row(32'hffffffff, 32'h00001234, 1'b1, 1'b1, 2'd2,
            make_result(32'hffffffff, 8'd3, 1'b0, 1'b0),
            make_result(32'hfe000203, 8'd0, 1'b0, 1'b1));
    add_row(32'h0, 32'h0, 1'b0, 1'b1, 2'd0, none, none);
    add_row(32'hffff0000, 32'hffff0000, 1'b0, 1'b1, 2'd0, none, none);
    add_row(32'h0000ffff, 32'h00008000, 1'b1, 1'b1, 2'd2,
            make_result(32'h0000ffff, 8'd1, 1'b0, 1'b0),
            make_result(32'hfe000201, 8'd0, 1'b0, 1'b1));
    add_setting(8'hff, 13'd3);
    add_row(32'h0, 32'h1, 1'b0, 1'b1, 2'd1, make_result(32'h1, 8'd1, 1'b0, 1'b0), none);
    add_row(32'h80000001, 32'h0, 1'b0, 1'b0, 2'd0, none, none);
    add_row(32'h5a5a5a5a, 32'h0, 1'b0, 1'b1, 2'd1, overflow, none);
    add_row(32'hffffffff, 32'hffffffff, 1'b0, 1'b1, 2'd0, none, none);
    add_row(32'h0, 32'h0, 1'b1, 1'b1, 2'd0, none, none);
    add_row(32'h2, 32'h0, 1'b1, 1'b1, 2'd2, make_result(32'h2, 8'd1, 1'b0, 1'b0),
            make_result(32'hfeff0201, 8'd0, 1'b0, 1'b1));
    add_row(32'h1, 32'h1, 1'b0, 1'b0, 2'd0, none, none);
    add_row(32'h1, 32'h1, 1'b0, 1'b0, 2'd0, none, none);
    add_row(32'h1, 32'h1, 1'b1, 1'b1, 2'd1, overflow, none);
    add_row(32'h0, 32'h0, 1'b1, 1'b1, 2'd1, make_result(32'hfeff0200, 8'd0, 1'b0, 1'b1), none);
    add_setting(8'ha5, 13'd0);
    add_row(32'h0, 32'h0, 1'b0, 1'b1, 2'd0, none, none);
    add_row(32'h0, 32'h0000ffff, 1'b0, 1'b1, 2'd1, overflow, none);
    add_row(32'h0, 32'h0, 1'b1, 1'b1, 2'd0, none, none);
    add_row(32'h0, 32'h0, 1'b1, 1'b1, 2'd1, make_result(32'hfea50200, 8'd0, 1'b0, 1'b1), none);
    add_setting(8'ha5, 13'd1);
    add_row(32'h0, 32'h1, 1'b1, 1'b1, 2'd1, overflow, none);
    add_row(32'h0, 32'h0, 1'b1, 1'b1, 2'd1, make_result(32'hfea50200, 8'd0, 1'b0, 1'b1), none);
    add_setting(8'h3c, 13'd8191);
    add_row(32'h12345678, 32'h0, 1'b1, 1'b0, 2'd0, none, none);
    add_row(32'h0, 32'h0, 1'b1, 1'b0, 2'd0, none, none);

    repeat (4) @(negedge clk);
    rst = 1'b0;

    gaps_on = 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.reconfig) set_config(row.ident, row.capacity);
      else send_channel(row.word_a, row.word_b, row.last, row.typed, row.count,
                        row.res0, row.res1);
    end

    // Random events under a range of register settings, extremes included.
    for (int p = 0; p < 8; p++) begin
      ident = tdczs_pkg::IDENT_W'($urandom);
      case (p)
        0: begin
          capacity = 13'd2;
          ident = 8'h00;
        end
        1: begin
          capacity = tdczs_pkg::CAP_RESET;
          ident = 8'hff;
        end
        2: capacity = 13'd8191;
        3: capacity = tdczs_pkg::CAP_W'($urandom_range(1, 8));
        4: capacity = tdczs_pkg::CAP_W'($urandom_range(0, 300));
        5: capacity = 13'd4096;
        6: capacity = 13'd1;
        default: capacity = tdczs_pkg::CAP_W'($urandom_range(0, 8191));
      endcase
      set_config(ident, capacity);
      if (p == 0) write_register(REG_SPARE, tdczs_pkg::CFG_DATA_W'($urandom));
      gaps_on = (p % 3 != 0);
      run_events(75);
    end

    // Long events: a full count of 255 hits, then a counter overflow mid-event.
    set_config(tdczs_pkg::IDENT_W'($urandom), 13'd4096);
    gaps_on = 1'($urandom_range(0, 1));
    // Close whatever event the random part left open so the count starts at zero.
    send_channel(reading(1'b0), reading(1'b0), 1'b1, 1'b0, 2'd0, none, none);
    for (int c = 0; c < 255; c++) send_channel(reading(1'b1), reading(1'b0), c == 254, 1'b0,
                                               2'd0, none, none);
    for (int c = 0; c < 258; c++) send_channel(reading(1'b0), reading(1'b1), c == 257, 1'b0,
                                               2'd0, none, none);
    send_channel(reading(1'b0), reading(1'b0), 1'b1, 1'b0, 2'd0, none, none);

    // Let the last results drain, then keep watching for strays before judging the run.
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tdczs_pkg.sv
hw/rtl/tdczs_lane.sv
hw/rtl/tdczs_merge.sv
hw/rtl/tdczs_queue.sv
hw/rtl/tdc_zero_suppress_packer.sv
dv/testbench.sv
